FILE: rtl/gtcp_pkg.sv
// ----------------------------------------------------------------------------
// gtcp_pkg
// Types and constants for the GPIO text command parser.
// ----------------------------------------------------------------------------
package gtcp_pkg;

    localparam int MAX_CHARS_DEFAULT = 16;
    localparam logic [7:0] MAX_PIN_RESET = 8'd223;
    localparam logic [7:0] PIN_SAT = 8'd255;

    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_O    = 8'h6f;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_L    = 8'h6c;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_SUBCMD = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        CMD_GET    = 3'd0,
        CMD_INPUT  = 3'd1,
        CMD_SET    = 3'd2,
        CMD_OUTPUT = 3'd3,
        CMD_ALL    = 3'd4
    } t_cmd;

endpackage

FILE: rtl/gpio_text_command_parser_unit.sv
// ----------------------------------------------------------------------------
// gpio_text_command_parser_unit
// Character-serial parser for get/set GPIO text commands.
//
// Input channel (i_valid/o_ready) takes one character item per cycle while
// o_ready is high, with a last flag. Output channel (o_valid/i_ready) gives
// one decoded result item for each command, on the character flagged last.
// The result is in the output register in the cycle after the last character
// is accepted. Throughput: one character per cycle while o_ready is high,
// set by the single parse step between the state registers and the result
// register. Only the first MAX_CHARS characters of a command are parsed; the
// rest are skipped but a last flag on them still ends the command.
// The user must write the max_pin register through i_cfg_wr_en/i_cfg_wr_data
// only while the block is idle; the block does not enforce this. Reset: 223.
// Reset clears the parse state and drops o_valid. When the receiver stalls
// with a result held, o_ready falls until the result is taken.
// ----------------------------------------------------------------------------
module gpio_text_command_parser_unit
    import gtcp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_status,
    output logic [2:0] o_command,
    output logic [7:0] o_pin,
    output logic       o_level
);

    localparam int POS_W = $clog2(MAX_CHARS + 1);

    logic [7:0]       r_max_pin;
    logic [POS_W-1:0] r_pos,   n_pos;
    t_phase           r_phase, n_phase;
    t_cmd             r_cmd,   n_cmd;
    logic [7:0]       r_acc,   n_acc;
    logic             r_ovf,   n_ovf;
    logic             r_lvl,   n_lvl;
    logic             r_err,   n_err;

    logic             r_out_valid;
    logic             r_out_status, n_out_status;
    logic [2:0]       r_out_command, n_out_command;
    logic [7:0]       r_out_pin, n_out_pin;
    logic             r_out_level, n_out_level;

    logic             accept;
    logic             is_digit;
    logic [3:0]       dval;
    logic [11:0]      prod;
    logic [7:0]       dig_acc;
    logic             dig_ovf;
    logic             bad;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign dval     = 4'(i_char_code - CH_ZERO);
    assign prod     = ({4'd0, r_acc} * 12'd10) + {8'd0, dval};

    always_comb begin
        if (r_ovf || (prod > {4'd0, PIN_SAT})) begin
            dig_ovf = 1'b1;
            dig_acc = PIN_SAT;
        end else begin
            dig_ovf = 1'b0;
            dig_acc = prod[7:0];
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_lvl   = r_lvl;
        n_err   = r_err;

        if (r_pos < POS_W'(MAX_CHARS)) begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                PH_PREFIX: begin
                    if (r_pos == POS_W'(0)) begin
                        if (i_char_code == CH_G) begin
                            n_cmd = CMD_GET;
                        end else if (i_char_code == CH_S) begin
                            n_cmd = CMD_SET;
                        end else begin
                            n_err   = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end else if (r_pos == POS_W'(1)) begin
                        if (i_char_code != CH_E) begin
                            n_err   = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        if (i_char_code != CH_T) begin
                            n_err   = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = (r_cmd == CMD_GET) ? PH_DIGITS : PH_SUBCMD;
                        end
                    end
                end
                PH_SUBCMD: begin
                    n_phase = PH_DIGITS;
                    if (is_digit) begin
                        n_cmd = CMD_SET;
                        n_acc = dig_acc;
                        n_ovf = dig_ovf;
                    end else if (i_char_code == CH_I) begin
                        n_cmd = CMD_INPUT;
                    end else if (i_char_code == CH_O) begin
                        n_cmd = CMD_OUTPUT;
                    end else if (i_char_code == CH_A) begin
                        n_cmd = CMD_ALL;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        n_acc = dig_acc;
                        n_ovf = dig_ovf;
                    end else if (r_cmd > CMD_INPUT) begin
                        if (i_char_code == CH_H) begin
                            n_lvl   = 1'b1;
                            n_phase = PH_DONE;
                        end else if (i_char_code == CH_L) begin
                            n_lvl   = 1'b0;
                            n_phase = PH_DONE;
                        end else begin
                            n_err   = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end

        bad = n_err || (n_phase == PH_PREFIX) || (n_phase == PH_SUBCMD)
            || ((n_phase == PH_DIGITS) && (n_cmd > CMD_INPUT))
            || n_ovf || (n_acc > r_max_pin);

        if (bad) begin
            n_out_status  = 1'b1;
            n_out_command = CMD_GET;
            n_out_pin     = 8'd0;
            n_out_level   = 1'b0;
        end else begin
            n_out_status  = 1'b0;
            n_out_command = n_cmd;
            n_out_pin     = n_acc;
            n_out_level   = n_lvl;
        end

        // end of command: parse state back to reset
        if (i_last_char) begin
            n_pos   = '0;
            n_phase = PH_PREFIX;
            n_cmd   = CMD_GET;
            n_acc   = 8'd0;
            n_ovf   = 1'b0;
            n_lvl   = 1'b0;
            n_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pin   <= MAX_PIN_RESET;
            r_pos       <= '0;
            r_phase     <= PH_PREFIX;
            r_cmd       <= CMD_GET;
            r_acc       <= 8'd0;
            r_ovf       <= 1'b0;
            r_lvl       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_pin <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_lvl   <= n_lvl;
                r_err   <= n_err;
            end
            if (accept && i_last_char) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_char) begin
            r_out_status  <= n_out_status;
            r_out_command <= n_out_command;
            r_out_pin     <= n_out_pin;
            r_out_level   <= n_out_level;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_command = r_out_command;
    assign o_pin     = r_out_pin;
    assign o_level   = r_out_level;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_command == CMD_GET && o_pin == 8'd0 && !o_level))
        else $error("error result carries nonzero fields");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_char) |=> o_valid)
        else $error("last item gave no result");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_char) |=> (r_pos == '0 && r_phase == PH_PREFIX && !r_err
                                     && !r_ovf && r_acc == 8'd0))
        else $error("parse state not cleared after command");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_CHARS))
        else $error("character position past limit");

endmodule
